/* hdl/nsdr_pkg.sv */
// Shared types, constants and microcode program of the NAF signed-digit recoder.
package nsdr_pkg;

   // Widths of the result fields.
   localparam int STEP_W = 33;
   localparam int EXP_W  = 5;

   // Digit limit per input value and the width of its counter.
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = 4;

   // Microprogram address width and step addresses.
   localparam int UPC_W = 1;
   localparam logic [UPC_W-1:0] UPC_LOAD = 1'b0;
   localparam logic [UPC_W-1:0] UPC_SCAN = 1'b1;

   // Jump conditions that a control word can test.
   typedef enum logic [0:0] {
      COND_ACCEPT = 1'b0,
      COND_DONE   = 1'b1
   } cond_type;

   // One control word of the microprogram.
   typedef struct packed {
      logic             load_en;
      logic             scan_en;
      cond_type         cond;
      logic [UPC_W-1:0] target;
   } ctrl_word_type;

   // Status fed back from the datapath to the sequencer.
   typedef struct packed {
      logic accept;
      logic rem_zero;
   } status_type;

   // Microprogram ROM: wait for a value and load it, then scan one bit
   // position per step until the remaining value is zero.
   function automatic ctrl_word_type ucode_word(input logic [UPC_W-1:0] addr);
      ctrl_word_type w;
      case (addr)
         UPC_LOAD: w = '{load_en: 1'b1, scan_en: 1'b0, cond: COND_ACCEPT, target: UPC_SCAN};
         UPC_SCAN: w = '{load_en: 1'b0, scan_en: 1'b1, cond: COND_DONE,   target: UPC_LOAD};
         default:  w = '{load_en: 1'b1, scan_en: 1'b0, cond: COND_ACCEPT, target: UPC_SCAN};
      endcase
      return w;
   endfunction

endpackage

/* hdl/naf_signed_digit_recoder_unit.sv */
// Top level of the NAF signed-digit recoder.
// Recodes one signed VALUE_WIDTH-bit integer per transaction into its
// non-adjacent form and returns one transaction per nonzero digit, up to 16
// digits from least to most significant, as +2^e or -2^e with the digit's
// sign, exponent and a last flag; zero returns nothing. A microcoded
// sequencer loads the value and then scans one bit position per cycle, while
// the result side does not stall a digit, until the remaining value is zero.
// The block takes one value at a time; a new value is accepted once the
// previous one is fully scanned, even while its final digit still waits in
// the result register.
module naf_signed_digit_recoder_unit #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [VALUE_WIDTH-1:0]      req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [nsdr_pkg::STEP_W-1:0] rsp_step,
   output logic                        rsp_negative,
   output logic [nsdr_pkg::EXP_W-1:0]  rsp_exponent,
   output logic                        rsp_last
);

   nsdr_pkg::ctrl_word_type ctrl;
   nsdr_pkg::status_type    status;
   logic                    accept;
   logic                    rem_zero;

   // The input is open only on the load step of the program.
   assign req_stall = !ctrl.load_en;
   assign accept    = req_valid && ctrl.load_en;
   assign status    = '{accept: accept, rem_zero: rem_zero};

   nsdr_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   nsdr_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .accept       (accept),
      .value        (req_value),
      .rem_zero     (rem_zero),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_step     (rsp_step),
      .rsp_negative (rsp_negative),
      .rsp_exponent (rsp_exponent),
      .rsp_last     (rsp_last)
   );

endmodule

/* hdl/nsdr_sequencer.sv */
// Microcode sequencer: step counter, control ROM and conditional jumps.
module nsdr_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  nsdr_pkg::status_type   status,
   output nsdr_pkg::ctrl_word_type ctrl
);

   logic [nsdr_pkg::UPC_W-1:0] upc_ff;
   logic [nsdr_pkg::UPC_W-1:0] upc_in;
   logic                       taken;

   // Fetch the current control word.
   assign ctrl = nsdr_pkg::ucode_word(upc_ff);

   // Evaluate the jump condition; otherwise stay on the current step.
   always_comb begin
      case (ctrl.cond)
         nsdr_pkg::COND_ACCEPT: taken = status.accept;
         nsdr_pkg::COND_DONE:   taken = status.rem_zero;
         default:               taken = 1'b0;
      endcase
      upc_in = taken ? ctrl.target : upc_ff;
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= nsdr_pkg::UPC_LOAD;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

/* hdl/nsdr_datapath.sv */
// Working register, digit extraction and result register of the recoder.
module nsdr_datapath #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  nsdr_pkg::ctrl_word_type      ctrl,
   input  logic                         accept,
   input  logic [VALUE_WIDTH-1:0]       value,
   output logic                         rem_zero,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [nsdr_pkg::STEP_W-1:0]  rsp_step,
   output logic                         rsp_negative,
   output logic [nsdr_pkg::EXP_W-1:0]   rsp_exponent,
   output logic                         rsp_last
);

   localparam int REM_W = VALUE_WIDTH + 1;
   localparam int POS_W = $clog2(VALUE_WIDTH + 2);

   logic signed [REM_W-1:0]        rem_ff, rem_in;
   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [nsdr_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic                           valid_ff, valid_in;
   logic [nsdr_pkg::STEP_W-1:0]    step_ff, step_in;
   logic                           neg_ff, neg_in;
   logic [nsdr_pkg::EXP_W-1:0]     exp_ff, exp_in;
   logic                           last_ff, last_in;

   logic                           odd;
   logic                           neg;
   logic                           out_free;
   logic                           emit;
   logic                           advance;
   logic                           at_limit;
   logic signed [REM_W-1:0]        adjusted;
   logic [nsdr_pkg::STEP_W-1:0]    mag;

   assign rem_zero = (rem_ff == '0);

   // Digit of the current position: +1 or -1 when the remaining value is odd.
   assign odd      = rem_ff[0];
   assign neg      = rem_ff[1];
   assign adjusted = neg ? rem_ff + REM_W'(1) : rem_ff - REM_W'(1);
   assign mag      = nsdr_pkg::STEP_W'(1) << pos_ff;
   assign at_limit = (cnt_ff == nsdr_pkg::CNT_W'(nsdr_pkg::MAX_RESULTS - 1));

   // A digit is emitted only when the result register is free or draining.
   assign out_free = !valid_ff || !rsp_stall;
   assign emit     = ctrl.scan_en && !rem_zero && odd && out_free;
   assign advance  = ctrl.scan_en && !rem_zero && (!odd || out_free);

   // Working register update: load, or subtract the digit and shift.
   always_comb begin
      rem_in = rem_ff;
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      if (ctrl.load_en && accept) begin
         rem_in = REM_W'(signed'(value));
         pos_in = '0;
         cnt_in = '0;
      end else if (advance) begin
         pos_in = pos_ff + POS_W'(1);
         if (odd) begin
            cnt_in = cnt_ff + nsdr_pkg::CNT_W'(1);
            // Keep the shift signed so a negative remainder stays negative.
            if (at_limit) begin
               rem_in = '0;
            end else begin
               rem_in = adjusted >>> 1;
            end
         end else begin
            rem_in = rem_ff >>> 1;
         end
      end
   end

   // Result register update.
   always_comb begin
      valid_in = valid_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      exp_in   = exp_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         step_in  = neg ? -mag : mag;
         neg_in   = neg;
         exp_in   = nsdr_pkg::EXP_W'(pos_ff);
         last_in  = (adjusted == '0) || at_limit;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= '0;
         pos_ff   <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         rem_ff   <= rem_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      neg_ff  <= neg_in;
      exp_ff  <= exp_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_step     = step_ff;
   assign rsp_negative = neg_ff;
   assign rsp_exponent = exp_ff;
   assign rsp_last     = last_ff;

endmodule

/* hdl/nsdr_checker.sv */
// Port-level checker of the NAF signed-digit recoder and its bind.
module nsdr_checker #(
   parameter int VALUE_WIDTH = 32
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [VALUE_WIDTH-1:0]      req_value,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [nsdr_pkg::STEP_W-1:0] rsp_step,
   input logic                        rsp_negative,
   input logic [nsdr_pkg::EXP_W-1:0]  rsp_exponent,
   input logic                        rsp_last
);

   logic [nsdr_pkg::STEP_W-1:0] pow2;
   assign pow2 = nsdr_pkg::STEP_W'(1) << rsp_exponent;

   // A stalled result transaction holds its valid and payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_step) && $stable(rsp_last)
         && $stable(rsp_negative) && $stable(rsp_exponent))
      else $error("stalled result changed");

   // The step value agrees with the digit sign and exponent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_step == (rsp_negative ? -pow2 : pow2))
      else $error("step does not match sign and exponent");

   // An accepted value closes the input for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted twice in a row");

   // A value whose low bit is clear cannot yield a digit at exponent zero
   // in the cycle right after it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_value[0] && !(rsp_valid && rsp_stall)
         |=> !(rsp_valid && rsp_exponent == '0 && $rose(rsp_valid)))
      else $error("digit emitted before the value was scanned");

endmodule

bind naf_signed_digit_recoder_unit nsdr_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_nsdr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_value    (req_value),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_step     (rsp_step),
   .rsp_negative (rsp_negative),
   .rsp_exponent (rsp_exponent),
   .rsp_last     (rsp_last)
);

/* tb/naf_digit_checker.sv */
// Checker for the NAF recoder: watches both channels, predicts digits and compares them.
module naf_digit_checker #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [VALUE_WIDTH-1:0]      req_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [nsdr_pkg::STEP_W-1:0] rsp_step,
   input  logic                        rsp_negative,
   input  logic [nsdr_pkg::EXP_W-1:0]  rsp_exponent,
   input  logic                        rsp_last,
   output int                          fail_count,
   output int                          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // One expected digit of a recoded value.
   typedef struct packed {
      logic [nsdr_pkg::STEP_W-1:0] step;
      logic                        negative;
      logic [nsdr_pkg::EXP_W-1:0]  exponent;
      logic                        last;
   } naf_digit_type;

   naf_digit_type naf_digits_due[$];
   int            mismatches = 0;

   // Recode one value into its non-adjacent form, least significant digit first.
   function automatic void queue_naf_digits(input logic [VALUE_WIDTH-1:0] value);
      logic signed [VALUE_WIDTH+1:0] rest;
      logic [nsdr_pkg::STEP_W-1:0]   weight;
      naf_digit_type                 digit;
      int                            pos;
      int                            count;
      rest  = {{2{value[VALUE_WIDTH-1]}}, value};
      pos   = 0;
      count = 0;
      while (rest != 0 && pos < 64) begin
         // An odd remainder yields a digit of +1 or -1, picked so the next bit clears.
         if (rest[0]) begin
            weight         = nsdr_pkg::STEP_W'(1) << pos;
            digit.negative = rest[1];
            if (rest[1]) begin
               rest       = rest + 1;
               digit.step = -weight;
            end else begin
               rest       = rest - 1;
               digit.step = weight;
            end
            digit.exponent = nsdr_pkg::EXP_W'(pos);
            count++;
            digit.last = (rest == 0) || (count == nsdr_pkg::MAX_RESULTS);
            naf_digits_due = {naf_digits_due, digit};
            if (count == nsdr_pkg::MAX_RESULTS)
               rest = '0;
         end
         rest = rest >>> 1;
         pos++;
      end
   endfunction

   // Count a failure and report it.
   function automatic void flag_mismatch(input string field, input longint want,
                                         input longint got);
      mismatches++;
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
   endfunction

   // Predict on every accepted value, then compare every accepted digit.
   always @(posedge clock) begin
      naf_digit_type want;
      if (reset) begin
         naf_digits_due.delete();
      end else begin
         if (req_valid && !req_stall)
            queue_naf_digits(req_value);
         if (rsp_valid && !rsp_stall) begin
            if (naf_digits_due.size() == 0) begin
               flag_mismatch("unexpected digit, step", 0, rsp_step);
            end else begin
               want = naf_digits_due.pop_front();
               if (rsp_step !== want.step)
                  flag_mismatch("step", want.step, rsp_step);
               if (rsp_negative !== want.negative)
                  flag_mismatch("negative", want.negative, rsp_negative);
               if (rsp_exponent !== want.exponent)
                  flag_mismatch("exponent", want.exponent, rsp_exponent);
               if (rsp_last !== want.last)
                  flag_mismatch("last", want.last, rsp_last);
            end
         end
      end
      pending    <= naf_digits_due.size();
      fail_count <= mismatches;
   end

endmodule

/* tb/tb_top.sv */
// Top of the NAF recoder testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_WIDTH = 32;

   // Edge values: signs, the most negative value, dense and sparse digit patterns.
   localparam logic [VALUE_WIDTH-1:0] EDGE_VALUES [22] = '{
      32'h00000000, 32'h00000001, 32'hFFFFFFFF, 32'h00000002, 32'h00000003,
      32'hFFFFFFFE, 32'hFFFFFFFD, 32'h00000007, 32'h7FFFFFFF, 32'h80000000,
      32'h80000001, 32'h55555555, 32'hAAAAAAAA, 32'h40000000, 32'hC0000000,
      32'h6DB6DB6D, 32'h33333333, 32'h12345678, 32'hDEADBEEF, 32'h0000000B,
      32'hBFFFFFFF, 32'h00000000
   };

   logic                        clock;
   logic                        reset     = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [VALUE_WIDTH-1:0]      req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [nsdr_pkg::STEP_W-1:0] rsp_step;
   logic                        rsp_negative;
   logic [nsdr_pkg::EXP_W-1:0]  rsp_exponent;
   logic                        rsp_last;
   int                          fail_count;
   int                          pending;

   bit sender_idles   = 1'b0;
   bit receiver_idles = 1'b0;
   bit hold_request   = 1'b0;

   naf_signed_digit_recoder_unit #(.VALUE_WIDTH(VALUE_WIDTH)) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_step     (rsp_step),
      .rsp_negative (rsp_negative),
      .rsp_exponent (rsp_exponent),
      .rsp_last     (rsp_last)
   );

   naf_digit_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_step     (rsp_step),
      .rsp_negative (rsp_negative),
      .rsp_exponent (rsp_exponent),
      .rsp_last     (rsp_last),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard limit on the run.
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // Offer one value until it is accepted, then maybe leave a gap.
   task automatic offer_value(input logic [VALUE_WIDTH-1:0] value);
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Random value drawn from a mix of shapes that stress the recoding.
   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom & $urandom & $urandom;
         1: return VALUE_WIDTH'($urandom_range(0, 511)) - VALUE_WIDTH'(256);
         2: return 32'h55555555 ^ ($urandom & $urandom & $urandom);
         3: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return 32'h80000000 ^ (32'd1 << $urandom_range(0, 31));
               2: return 32'h7FFFFFFF ^ (32'd1 << $urandom_range(0, 31));
               default: return 32'hAAAAAAAA ^ (32'd1 << $urandom_range(0, 31));
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Receiver: short random stall bursts, plus one long hold on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall    <= 1'b0;
            hold_request = 1'b0;
         end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed edge cases with both sides idling.
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      foreach (EDGE_VALUES[i])
         offer_value(EDGE_VALUES[i]);

      // Random traffic with idling on both sides.
      repeat (150)
         offer_value(pick_value());

      // Back-pressure: the receiver holds off while dense values keep coming.
      sender_idles = 1'b0;
      hold_request = 1'b1;
      repeat (12)
         offer_value(32'h55555555 ^ ($urandom & $urandom));
      sender_idles = 1'b1;

      repeat (180)
         offer_value(pick_value());

      // Closing stretch at full rate on both sides.
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      repeat (70)
         offer_value(pick_value());
      req_valid <= 1'b0;

      // Let the last prediction land, drain, then watch for stray digits.
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
